// ----- design/assert_macros.svh -----
// Assertion helper macros shared by the design files.
// Pulled in by `include; depends on a clk and an rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition checked on every rising clk edge out of reset.
`define ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition in this cycle implies a property from the same cycle on.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition in this cycle implies a property in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/mtf_pkg.sv -----
// Shared types and constants for the move-to-front list.
// No dependencies; used by the interfaces, the cell and the top level.
`default_nettype none

package mtf_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int POS_W        = 8;
    localparam int ENTRY_CNT_W  = 9;
    localparam int STATUS_W     = 2;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_FIND   = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_APPENDED  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FOUND     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

    // Strobes from the sequencer to every cell of the row.
    typedef struct packed {
        logic compare;
        logic find;
        logic hit;
        logic append;
    } mtf_ctl_t;

endpackage

`default_nettype wire

// ----- design/mtf_if.sv -----
// Handshake channels for request and result beats of the move-to-front list.
// Depends on mtf_pkg for the payload widths.
`default_nettype none

interface mtf_in_if;
    import mtf_pkg::*;

    logic               valid;
    logic               ready;
    logic               op;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface mtf_out_if;
    import mtf_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [POS_W-1:0]       position;
    logic [ENTRY_CNT_W-1:0] entry_count;

    modport source (output valid, output status, output position, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input position, input entry_count,
                    output ready);
endinterface

`default_nettype wire

// ----- design/move_to_front_list.sv -----
// Move-to-front list: a row of mtf_cell slots driven by a two-state sequencer.
// Depends on mtf_pkg, mtf_if, mtf_cell and assert_macros.svh.
//
// In the accept cycle every cell registers whether its entry equals the key; in
// the execute state, once the output register is free, the first-match flag and
// its position ripple down the cell row, on a find hit the cells up to the match
// shift back one slot with the key entering slot 0, an append with room writes
// the key at the entry count, and the result is loaded into the output register.
// A new request is taken the cycle after, even while the last result still waits;
// the row holds one request at a time, so none is taken before the last executes.
// Entries start undefined and are only read below the entry count.
`default_nettype none

`include "assert_macros.svh"

module move_to_front_list #(
    parameter int CAPACITY = mtf_pkg::CAPACITY_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    mtf_in_if.sink    items,
    mtf_out_if.source results
);
    import mtf_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t                 state_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   op_reg;
    logic [VALUE_W-1:0]     key_reg;
    logic                   out_valid_reg;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [POS_W-1:0]       position_reg, position_next;
    logic [ENTRY_CNT_W-1:0] entry_count_reg;

    logic      in_fire, exec_fire, not_full;
    mtf_ctl_t  ctl;

    logic                seen_w [0:CAPACITY];
    logic [POS_W-1:0]    pos_w  [0:CAPACITY];
    logic [VALUE_W-1:0]  ent_w  [0:CAPACITY-1];
    logic [CAPACITY-1:0] first_vec;

    assign items.ready = (state_reg == ST_IDLE);
    assign in_fire     = items.valid && items.ready;
    assign exec_fire   = (state_reg == ST_EXEC) && (!out_valid_reg || results.ready);
    assign not_full    = (count_reg < CNT_W'(CAPACITY));

    assign ctl.compare = in_fire;
    assign ctl.find    = exec_fire && (op_reg == OP_FIND);
    assign ctl.hit     = seen_w[CAPACITY];
    assign ctl.append  = exec_fire && (op_reg == OP_APPEND) && not_full;

    assign seen_w[0] = 1'b0;
    assign pos_w[0]  = '0;

    genvar g;
    for (g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [VALUE_W-1:0] prev_entry;
        if (g == 0)
        begin : g_head
            assign prev_entry = key_reg;
        end
        else
        begin : g_body
            assign prev_entry = ent_w[g-1];
        end

        mtf_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (g)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .count      (count_reg),
            .key        (in_fire ? items.value : key_reg),
            .prev_entry (prev_entry),
            .seen_in    (seen_w[g]),
            .pos_in     (pos_w[g]),
            .entry      (ent_w[g]),
            .seen_out   (seen_w[g+1]),
            .pos_out    (pos_w[g+1]),
            .first      (first_vec[g])
        );
    end

    always_comb
    begin
        count_next    = count_reg;
        position_next = '0;
        if (op_reg == OP_APPEND)
        begin
            if (not_full)
            begin
                status_next = STATUS_APPENDED;
                count_next  = count_reg + CNT_W'(1);
            end
            else
            begin
                status_next = STATUS_FULL;
            end
        end
        else if (ctl.hit)
        begin
            status_next   = STATUS_FOUND;
            position_next = pos_w[CAPACITY];
        end
        else
        begin
            status_next = STATUS_NOT_FOUND;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    if (exec_fire)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (exec_fire)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload: hold the request and the result beat
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg  <= items.op;
            key_reg <= items.value;
        end
        if (exec_fire)
        begin
            status_reg      <= status_next;
            position_reg    <= position_next;
            entry_count_reg <= ENTRY_CNT_W'(count_next);
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.status      = status_reg;
    assign results.position    = position_reg;
    assign results.entry_count = entry_count_reg;

    `ASSERT_NOW(a_count_bound, count_reg <= CNT_W'(CAPACITY), "entry count above capacity")
    `ASSERT_IMPL(a_one_first, state_reg == ST_EXEC, $onehot0(first_vec),
        "more than one cell claims the first match")
    `ASSERT_NEXT(a_exec_result, exec_fire, out_valid_reg && state_reg == ST_IDLE,
        "executed request did not produce a result beat")
    `ASSERT_NEXT(a_find_count, exec_fire && op_reg == OP_FIND, $stable(count_reg),
        "find changed the entry count")
    `ASSERT_NEXT(a_append_count, ctl.append, count_reg == $past(count_reg) + CNT_W'(1),
        "append did not advance the entry count")

endmodule

`default_nettype wire

// ----- design/mtf_cell.sv -----
// One slot of the move-to-front row: holds an entry and its registered match.
// Depends on mtf_pkg for widths and the control struct.
`default_nettype none

module mtf_cell #(
    parameter int CAPACITY = mtf_pkg::CAPACITY_DEF,
    parameter int IDX      = 0,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  wire logic                         clk,
    input  wire mtf_pkg::mtf_ctl_t            ctl,
    input  wire logic [CNT_W-1:0]             count,
    input  wire logic [mtf_pkg::VALUE_W-1:0]  key,
    input  wire logic [mtf_pkg::VALUE_W-1:0]  prev_entry,
    input  wire logic                         seen_in,
    input  wire logic [mtf_pkg::POS_W-1:0]    pos_in,
    output logic      [mtf_pkg::VALUE_W-1:0]  entry,
    output logic                              seen_out,
    output logic      [mtf_pkg::POS_W-1:0]    pos_out,
    output logic                              first
);
    import mtf_pkg::*;

    logic [VALUE_W-1:0] entry_reg, entry_next;
    logic               match_reg, match_next;

    always_comb
    begin
        match_next = match_reg;
        if (ctl.compare)
        begin
            match_next = (entry_reg == key) && (CNT_W'(IDX) < count);
        end
    end

    assign first    = match_reg & ~seen_in;
    assign seen_out = seen_in | match_reg;
    assign pos_out  = pos_in | (first ? POS_W'(IDX) : '0);

    always_comb
    begin
        entry_next = entry_reg;
        // advance from the neighbor up to and including the first match
        if (ctl.find && ctl.hit && !seen_in)
        begin
            entry_next = prev_entry;
        end
        if (ctl.append && (count == CNT_W'(IDX)))
        begin
            entry_next = key;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        match_reg <= match_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

// ----- tb/sv/move_to_front_checker.sv -----
// Scoreboard for the move-to-front list: predicts each result from the request beats.
// Depends on mtf_pkg and the channel interfaces in mtf_if.
`timescale 1ns / 1ps

module move_to_front_checker
    import mtf_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic clk,
    input  logic rst_n,
    mtf_in_if    items,
    mtf_out_if   results,
    output int   mismatches,
    output int   outstanding
);

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [POS_W-1:0]       position;
        logic [ENTRY_CNT_W-1:0] entry_count;
    } mtf_result_t;

    logic [VALUE_W-1:0] slots [CAPACITY];
    int                 fill;
    mtf_result_t        pending_results [$];

    // Update the shadow list for one request and return the result it should produce.
    function automatic mtf_result_t apply_request(input logic op_i,
                                                  input logic [VALUE_W-1:0] key);
        mtf_result_t r;
        int          hit_at;
        r      = '0;
        hit_at = -1;
        if (op_i == OP_APPEND) begin
            if (fill < CAPACITY) begin
                slots[fill] = key;
                fill++;
                r.status = STATUS_APPENDED;
            end
            else begin
                r.status = STATUS_FULL;
            end
        end
        else begin
            for (int i = 0; i < fill; i++) begin
                if (hit_at < 0 && slots[i] == key)
                    hit_at = i;
            end
            if (hit_at >= 0) begin
                // shift the entries ahead of the match back one slot
                for (int j = hit_at; j > 0; j--)
                    slots[j] = slots[j-1];
                slots[0]   = key;
                r.status   = STATUS_FOUND;
                r.position = POS_W'(hit_at);
            end
            else begin
                r.status = STATUS_NOT_FOUND;
            end
        end
        r.entry_count = ENTRY_CNT_W'(fill);
        return r;
    endfunction

    task automatic check_field(input string name, input int expv, input int gotv);
        if (expv != gotv) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expv, gotv);
            mismatches++;
        end
    endtask

    initial begin
        fill        = 0;
        mismatches  = 0;
        outstanding = 0;
    end

    always @(posedge clk) begin : scoreboard
        mtf_result_t want;
        if (!rst_n) begin
            fill = 0;
            pending_results.delete();
        end
        else begin
            // compare first, so a stray result is not hidden by a request on the same edge
            if (results.valid && results.ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result beat with none expected, %s %0d %s %0d %s %0d",
                             $time, "status", results.status, "position", results.position,
                             "count", results.entry_count);
                    mismatches++;
                end
                else begin
                    want = pending_results.pop_front();
                    check_field("status", int'(want.status), int'(results.status));
                    check_field("position", int'(want.position), int'(results.position));
                    check_field("entry_count", int'(want.entry_count),
                                int'(results.entry_count));
                end
            end
            if (items.valid && items.ready)
                pending_results.push_back(apply_request(items.op, items.value));
        end
        outstanding = pending_results.size();
    end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the move-to-front list testbench: clock, reset, request and result stimulus.
// Depends on mtf_pkg, mtf_if, move_to_front_list and move_to_front_checker.
`timescale 1ns / 1ps

module testbench;
    import mtf_pkg::*;

    localparam int CAPACITY    = 16;
    localparam int ITEMS_PER   = 484;
    localparam int CYCLE_LIMIT = 200000;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   cycles;
    int   tx_idle_pct;
    int   rx_idle_pct;

    // values the list holds once full; finds draw most keys from here
    logic [VALUE_W-1:0] stored_vals [$];

    mtf_in_if  items ();
    mtf_out_if results ();

    move_to_front_list #(.CAPACITY(CAPACITY)) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results)
    );

    move_to_front_checker #(.CAPACITY(CAPACITY)) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .items       (items),
        .results     (results),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("%0t: timeout after %0d cycles", $time, cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    always @(negedge clk)
        results.ready <= ($urandom_range(0, 99) >= rx_idle_pct);

    task automatic send_item(input logic op_i, input logic [VALUE_W-1:0] value_i);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            items.valid <= 1'b0;
            items.op    <= 1'($urandom);
            items.value <= $urandom;
            @(negedge clk);
        end
        items.valid <= 1'b1;
        items.op    <= op_i;
        items.value <= value_i;
        do
            @(posedge clk);
        while (!items.ready);
        @(negedge clk);
    endtask

    task automatic append_value(input logic [VALUE_W-1:0] v);
        if (stored_vals.size() < CAPACITY)
            stored_vals.push_back(v);
        send_item(OP_APPEND, v);
    endtask

    task automatic drain_results();
        items.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic random_burst(input int n);
        logic [VALUE_W-1:0] key;
        int                 pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            key  = stored_vals[$urandom_range(0, stored_vals.size() - 1)];
            if (pick < 15) begin
                append_value($urandom_range(0, 3) == 0 ? key : $urandom);
            end
            else if (pick < 67) begin
                send_item(OP_FIND, key);
            end
            else if (pick < 82) begin
                // near miss: one bit off a stored value
                send_item(OP_FIND, key ^ (32'h1 << $urandom_range(0, VALUE_W - 1)));
            end
            else begin
                send_item(OP_FIND, $urandom);
            end
        end
    endtask

    initial begin
        rst_n         = 1'b0;
        items.valid   = 1'b0;
        items.op      = OP_APPEND;
        items.value   = '0;
        results.ready = 1'b0;
        tx_idle_pct   = 10;
        rx_idle_pct   = 79;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty list, extremes, duplicates, moves, fill and overflow
        send_item(OP_FIND, 32'h0000_0000);
        append_value(32'h8000_0000);
        append_value(32'h7FFF_FFFF);
        append_value(32'h0000_0000);
        append_value(32'hFFFF_FFFF);
        append_value(32'h7FFF_FFFF);
        send_item(OP_FIND, 32'h7FFF_FFFF);
        send_item(OP_FIND, 32'h7FFF_FFFF);
        send_item(OP_FIND, 32'hFFFF_FFFF);
        send_item(OP_FIND, 32'h1234_5678);
        append_value(32'hAAAA_AAAA);
        append_value(32'h5555_5555);
        for (int i = 1; i <= 9; i++)
            append_value(i * 32'h1111_1111 + 1);
        append_value(32'hDEAD_BEEF);
        send_item(OP_FIND, 9 * 32'h1111_1111 + 1);
        send_item(OP_FIND, 32'h8000_0001);

        // hold off until the list has answered everything
        drain_results();

        random_burst(ITEMS_PER);
        drain_results();
        tx_idle_pct = 79;
        rx_idle_pct = 10;
        random_burst(ITEMS_PER);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_burst(ITEMS_PER);

        drain_results();
        repeat (10) @(negedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
